[sv/idp_pkg.sv]
`timescale 1ns / 1ps
// idp_pkg: constants, types and helpers shared by the date-time parser.
// No dependencies.
package idp_pkg;

  localparam int MAX_CHARS = 64;
  localparam int CNT_W     = $clog2(MAX_CHARS + 1);
  localparam int ADDR_W    = $clog2(MAX_CHARS);

  // result status codes
  localparam logic [3:0] ST_OK     = 4'd0;
  localparam logic [3:0] ST_SYNTAX = 4'd1;
  localparam logic [3:0] ST_MONTH  = 4'd2;
  localparam logic [3:0] ST_DAY    = 4'd3;
  localparam logic [3:0] ST_HOUR   = 4'd4;
  localparam logic [3:0] ST_MINUTE = 4'd5;
  localparam logic [3:0] ST_SECOND = 4'd6;
  localparam logic [3:0] ST_ZHOUR  = 4'd7;
  localparam logic [3:0] ST_ZMIN   = 4'd8;

  // finest unit codes
  localparam logic [3:0] U_YEAR   = 4'd0;
  localparam logic [3:0] U_MONTH  = 4'd1;
  localparam logic [3:0] U_DAY    = 4'd3;
  localparam logic [3:0] U_HOUR   = 4'd4;
  localparam logic [3:0] U_MINUTE = 4'd5;
  localparam logic [3:0] U_SECOND = 4'd6;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;

  // handoff from loader to scanner
  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] len;
    logic             ovf;
  } idp_job_t;

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_spc(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic [4:0] month_days(input logic [6:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      7'd2:                      r = leap ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   r = 5'd30;
      default:                   r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

[sv/idp_front.sv]
`timescale 1ns / 1ps
// idp_front: character loader, string buffer and job handoff.
// Depends on idp_pkg.
module idp_front import idp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        char_byte_i,
  input  logic              last_char_i,
  output idp_job_t          job_o,
  input  logic              release_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0]       mem [MAX_CHARS];
  logic [7:0]       rd_data_q;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  idp_job_t         job_q, job_d;
  logic             acc, room;

  assign full      = job_q.valid;
  assign acc       = push && !job_q.valid;
  assign room      = count_q < CNT_W'(MAX_CHARS);
  assign job_o     = job_q;
  assign rd_data_o = rd_data_q;

  always_comb begin
    count_d = count_q;
    ovf_d   = ovf_q;
    job_d   = job_q;
    if (release_i) begin
      job_d.valid = 1'b0;
    end
    if (acc) begin
      if (room) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
      if (last_char_i) begin
        job_d.valid = 1'b1;
        job_d.len   = count_d;
        job_d.ovf   = ovf_d;
        count_d     = '0;
        ovf_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      job_q   <= '0;
    end else begin
      count_q <= count_d;
      ovf_q   <= ovf_d;
      job_q   <= job_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && room) begin
      mem[count_q[ADDR_W-1:0]] <= char_byte_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

endmodule

[sv/idp_scan.sv]
`timescale 1ns / 1ps
// idp_scan: walks the stored string, checks fields, holds the result register.
// Depends on idp_pkg.
module idp_scan import idp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  idp_job_t          job_i,
  output logic              release_o,
  output logic [ADDR_W-1:0] rd_addr_o,
  input  logic [7:0]        rd_data_i,
  output logic              empty,
  input  logic              pop,
  output logic [3:0]        status_o,
  output logic [6:0]        error_position_o,
  output logic [14:0]       year_o,
  output logic [3:0]        month_o,
  output logic [4:0]        day_o,
  output logic [4:0]        hour_o,
  output logic [5:0]        minute_o,
  output logic [5:0]        second_o,
  output logic [59:0]       fraction_atto_o,
  output logic [3:0]        best_unit_o,
  output logic              tz_present_o,
  output logic [11:0]       tz_offset_minutes_o
);

  localparam logic [5:0] S_IDLE = 6'd0,  S_LWS = 6'd1,   S_SIGN = 6'd2,  S_CHK0 = 6'd3;
  localparam logic [5:0] S_YEAR = 6'd4,  S_YDONE = 6'd5, S_MSEP = 6'd6,  S_MSEP2 = 6'd7;
  localparam logic [5:0] S_M1 = 6'd8,    S_M2 = 6'd9,    S_MCHK = 6'd10, S_D0 = 6'd11;
  localparam logic [5:0] S_D2 = 6'd12,   S_DCHK = 6'd13, S_H0 = 6'd14,   S_H2 = 6'd15;
  localparam logic [5:0] S_HCHK = 6'd16, S_COLM = 6'd17, S_MI0 = 6'd18,  S_MI2 = 6'd19;
  localparam logic [5:0] S_MICHK = 6'd20, S_COLS = 6'd21, S_S0 = 6'd22,  S_S2 = 6'd23;
  localparam logic [5:0] S_SCHK = 6'd24, S_FR = 6'd25,   S_FPAD = 6'd26, S_ZWS = 6'd27;
  localparam logic [5:0] S_ZH0 = 6'd28,  S_ZH2 = 6'd29,  S_ZCOL = 6'd30, S_ZM0 = 6'd31;
  localparam logic [5:0] S_ZM2 = 6'd32,  S_ZFIN = 6'd33, S_TWS = 6'd34,  S_FIN = 6'd35;

  logic [5:0]       st_q, st_d;
  logic [CNT_W-1:0] sp_q, sp_d, len_q, len_d, ys_q, ys_d;
  logic             fetch_q, fetch_d;
  logic             neg_q, neg_d, sep_on_q, sep_on_d, h2_q, h2_d, hms_q, hms_d;
  logic             tzn_q, tzn_d, tzp_q, tzp_d;
  logic [1:0]       ycnt_q, ycnt_d;
  logic [6:0]       yhi_q, yhi_d, ylo_q, ylo_d;
  logic [7:0]       sep_q, sep_d;
  logic [6:0]       mon_q, mon_d, day_q, day_d, hr_q, hr_d, mi_q, mi_d, se_q, se_d;
  logic [6:0]       zh_q, zh_d, zm_q, zm_d;
  logic [59:0]      frac_q, frac_d;
  logic [4:0]       nd_q, nd_d;
  logic [3:0]       unit_q, unit_d, code_q, code_d;
  logic [6:0]       epos_q, epos_d;
  logic [11:0]      tzoff_q, tzoff_d;

  logic             ov_q, ov_d;
  logic [3:0]       o_status_q;
  logic [6:0]       o_epos_q;
  logic [14:0]      o_year_q;
  logic [3:0]       o_mon_q;
  logic [4:0]       o_day_q, o_hr_q;
  logic [5:0]       o_mi_q, o_se_q;
  logic [59:0]      o_frac_q;
  logic [3:0]       o_unit_q;
  logic             o_tzp_q;
  logic [11:0]      o_tzoff_q;

  logic [7:0]       c;
  logic [3:0]       d;
  logic             at_end, left1, dg, sp_c, leap, wr;
  logic [13:0]      yval;
  logic [10:0]      offv;

  function automatic logic [6:0] two(input logic [6:0] v, input logic [3:0] dd);
    return 7'((v << 3) + (v << 1)) + 7'(dd);
  endfunction

  assign at_end    = sp_q >= len_q;
  assign left1     = len_q == (sp_q + CNT_W'(1));
  assign c         = at_end ? 8'h00 : rd_data_i;
  assign d         = c[3:0];
  assign dg        = is_dig(c);
  assign sp_c      = is_spc(c);
  assign rd_addr_o = sp_q[ADDR_W-1:0];
  assign leap      = (ylo_q[1:0] == 2'b00) && ((ylo_q != 7'd0) || (yhi_q[1:0] == 2'b00));
  assign yval      = 14'(yhi_q * 7'd100) + 14'(ylo_q);
  assign offv      = 11'(zh_q * 6'd60) + 11'(zm_q);
  assign wr        = (st_q == S_FIN) && (!ov_q || pop);
  assign release_o = wr;

  always_comb begin
    st_d = st_q;     sp_d = sp_q;     len_d = len_q;   ys_d = ys_q;
    fetch_d = 1'b0;  neg_d = neg_q;   sep_on_d = sep_on_q; h2_d = h2_q;
    hms_d = hms_q;   tzn_d = tzn_q;   tzp_d = tzp_q;   ycnt_d = ycnt_q;
    yhi_d = yhi_q;   ylo_d = ylo_q;   sep_d = sep_q;   mon_d = mon_q;
    day_d = day_q;   hr_d = hr_q;     mi_d = mi_q;     se_d = se_q;
    zh_d = zh_q;     zm_d = zm_q;     frac_d = frac_q; nd_d = nd_q;
    unit_d = unit_q; code_d = code_q; epos_d = epos_q; tzoff_d = tzoff_q;

    if (st_q == S_IDLE) begin
      if (job_i.valid) begin
        sp_d = '0; len_d = job_i.len; fetch_d = 1'b1;
        neg_d = 1'b0; sep_on_d = 1'b0; h2_d = 1'b0; hms_d = 1'b0;
        tzn_d = 1'b0; tzp_d = 1'b0; yhi_d = '0; ylo_d = '0;
        mon_d = 7'd1; day_d = 7'd1; hr_d = '0; mi_d = '0; se_d = '0;
        zh_d = '0; zm_d = '0; frac_d = '0; nd_d = '0; tzoff_d = '0;
        code_d = ST_OK; epos_d = '0; unit_d = U_YEAR;
        if (job_i.ovf) begin
          code_d = ST_SYNTAX; epos_d = 7'(MAX_CHARS); st_d = S_FIN;
        end else begin
          st_d = S_LWS;
        end
      end
    end else if (st_q == S_FIN) begin
      if (wr) st_d = S_IDLE;
    end else if (!fetch_q) begin
      case (st_q)
        S_LWS: begin
          if (!at_end && sp_c) begin sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; end
          else st_d = S_SIGN;
        end
        S_SIGN: begin
          st_d = S_CHK0;
          if (c == CH_MINUS) begin neg_d = 1'b1; sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; end
        end
        S_CHK0: begin
          if (at_end) begin code_d = ST_SYNTAX; st_d = S_FIN; end
          else begin ys_d = sp_q; ycnt_d = '0; st_d = S_YEAR; end
        end
        S_YEAR: begin
          if (!at_end && dg) begin
            case (ycnt_q)
              2'd0:    yhi_d = 7'(d);
              2'd1:    yhi_d = two(yhi_q, d);
              2'd2:    ylo_d = 7'(d);
              default: ylo_d = two(ylo_q, d);
            endcase
            ycnt_d = ycnt_q + 2'd1;
            sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1;
            if (ycnt_q == 2'd3) st_d = S_YDONE;
          end else begin
            yhi_d = '0; ylo_d = '0; sp_d = ys_q; fetch_d = 1'b1; st_d = S_YDONE;
          end
        end
        S_YDONE: begin
          if (at_end) begin unit_d = U_YEAR; st_d = S_FIN; end
          else st_d = S_MSEP;
        end
        S_MSEP: begin
          if (dg) st_d = S_M1;
          else if (c == CH_MINUS || c == CH_DOT || c == CH_SLASH || c == CH_BSL ||
                   c == CH_SPACE) begin
            sep_on_d = 1'b1; sep_d = c; sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1;
            st_d = S_MSEP2;
          end else begin code_d = ST_SYNTAX; st_d = S_FIN; end
        end
        S_MSEP2: begin
          if (at_end || !dg) begin code_d = ST_SYNTAX; st_d = S_FIN; end
          else st_d = S_M1;
        end
        S_M1: begin
          mon_d = 7'(d); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_M2;
        end
        S_M2: begin
          if (dg) begin
            mon_d = two(mon_q, d); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_MCHK;
          end else if (!sep_on_q) begin code_d = ST_SYNTAX; st_d = S_FIN; end
          else st_d = S_MCHK;
        end
        S_MCHK: begin
          if (mon_q < 7'd1 || mon_q > 7'd12) begin code_d = ST_MONTH; st_d = S_FIN; end
          else if (at_end) begin
            if (!sep_on_q) code_d = ST_SYNTAX;
            else unit_d = U_MONTH;
            st_d = S_FIN;
          end else if (sep_on_q) begin
            if (c != sep_q || left1) begin code_d = ST_SYNTAX; st_d = S_FIN; end
            else begin sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_D0; end
          end else st_d = S_D0;
        end
        S_D0: begin
          if (!dg) begin code_d = ST_SYNTAX; st_d = S_FIN; end
          else begin day_d = 7'(d); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_D2; end
        end
        S_D2: begin
          if (dg) begin
            day_d = two(day_q, d); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_DCHK;
          end else if (!sep_on_q) begin code_d = ST_SYNTAX; st_d = S_FIN; end
          else st_d = S_DCHK;
        end
        S_DCHK: begin
          if (day_q < 7'd1 || day_q > 7'(month_days(mon_q, leap))) begin
            code_d = ST_DAY; st_d = S_FIN;
          end else if (at_end) begin unit_d = U_DAY; st_d = S_FIN; end
          else if ((c != CH_T && c != CH_SPACE) || left1) begin
            code_d = ST_SYNTAX; st_d = S_FIN;
          end else begin sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_H0; end
        end
        S_H0: begin
          if (!dg) begin code_d = ST_SYNTAX; st_d = S_FIN; end
          else begin hr_d = 7'(d); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_H2; end
        end
        S_H2: begin
          st_d = S_HCHK;
          if (dg) begin
            h2_d = 1'b1; hr_d = two(hr_q, d); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1;
          end
        end
        S_HCHK: begin
          if (hr_q >= 7'd24) begin code_d = ST_HOUR; st_d = S_FIN; end
          else if (at_end) begin
            if (!h2_q) code_d = ST_SYNTAX;
            else unit_d = U_HOUR;
            st_d = S_FIN;
          end else if (c == CH_COLON) begin
            hms_d = 1'b1; sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_COLM;
          end else if (!dg) begin
            if (!h2_q) begin code_d = ST_SYNTAX; st_d = S_FIN; end
            else begin unit_d = U_HOUR; st_d = S_ZWS; end
          end else st_d = S_MI0;
        end
        S_COLM: begin
          if (at_end || !dg) begin code_d = ST_SYNTAX; st_d = S_FIN; end
          else st_d = S_MI0;
        end
        S_MI0: begin
          mi_d = 7'(d); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_MI2;
        end
        S_MI2: begin
          if (dg) begin
            mi_d = two(mi_q, d); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_MICHK;
          end else if (!hms_q) begin code_d = ST_SYNTAX; st_d = S_FIN; end
          else st_d = S_MICHK;
        end
        S_MICHK: begin
          if (mi_q >= 7'd60) begin code_d = ST_MINUTE; st_d = S_FIN; end
          else if (at_end) begin unit_d = U_MINUTE; st_d = S_FIN; end
          else if (hms_q && c == CH_COLON) begin
            sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_COLS;
          end else if (!(!hms_q && dg)) begin unit_d = U_MINUTE; st_d = S_ZWS; end
          else st_d = S_S0;
        end
        S_COLS: begin
          if (at_end || !dg) begin code_d = ST_SYNTAX; st_d = S_FIN; end
          else st_d = S_S0;
        end
        S_S0: begin
          se_d = 7'(d); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_S2;
        end
        S_S2: begin
          if (dg) begin
            se_d = two(se_q, d); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_SCHK;
          end else if (!hms_q) begin code_d = ST_SYNTAX; st_d = S_FIN; end
          else st_d = S_SCHK;
        end
        S_SCHK: begin
          if (se_q >= 7'd60) begin code_d = ST_SECOND; st_d = S_FIN; end
          else if (at_end || c != CH_DOT) begin unit_d = U_SECOND; st_d = S_ZWS; end
          else begin sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_FR; end
        end
        S_FR: begin
          if (nd_q < 5'd18 && !at_end && dg) begin
            frac_d = 60'((frac_q << 3) + (frac_q << 1)) + 60'(d);
            nd_d = nd_q + 5'd1; sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1;
          end else begin
            // unit follows the digit count in steps of three
            if (nd_q <= 5'd3)       unit_d = 4'd7;
            else if (nd_q <= 5'd6)  unit_d = 4'd8;
            else if (nd_q <= 5'd9)  unit_d = 4'd9;
            else if (nd_q <= 5'd12) unit_d = 4'd10;
            else if (nd_q <= 5'd15) unit_d = 4'd11;
            else                    unit_d = 4'd12;
            st_d = S_FPAD;
          end
        end
        S_FPAD: begin
          if (nd_q < 5'd18) begin
            frac_d = 60'((frac_q << 3) + (frac_q << 1)); nd_d = nd_q + 5'd1;
          end else st_d = S_ZWS;
        end
        S_ZWS: begin
          if (!at_end && sp_c) begin sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; end
          else if (at_end) st_d = S_FIN;
          else if (c == CH_Z) begin
            tzp_d = 1'b1; sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_TWS;
          end else if (c == CH_MINUS || c == CH_PLUS) begin
            tzn_d = (c == CH_MINUS); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_ZH0;
          end else st_d = S_TWS;
        end
        S_ZH0: begin
          if (at_end || !dg) begin code_d = ST_SYNTAX; st_d = S_FIN; end
          else begin zh_d = 7'(d); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_ZH2; end
        end
        S_ZH2: begin
          if (dg) begin
            zh_d = two(zh_q, d);
            if (zh_d >= 7'd24) begin code_d = ST_ZHOUR; st_d = S_FIN; end
            else begin sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_ZCOL; end
          end else st_d = S_ZCOL;
        end
        S_ZCOL: begin
          if (at_end) st_d = S_ZFIN;
          else begin
            st_d = S_ZM0;
            if (c == CH_COLON) begin sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; end
          end
        end
        S_ZM0: begin
          if (at_end || !dg) begin code_d = ST_SYNTAX; st_d = S_FIN; end
          else begin zm_d = 7'(d); sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_ZM2; end
        end
        S_ZM2: begin
          if (dg) begin
            zm_d = two(zm_q, d);
            if (zm_d >= 7'd60) begin code_d = ST_ZMIN; st_d = S_FIN; end
            else begin sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; st_d = S_ZFIN; end
          end else st_d = S_ZFIN;
        end
        S_ZFIN: begin
          tzp_d = 1'b1;
          tzoff_d = tzn_q ? -12'(offv) : 12'(offv);
          st_d = S_TWS;
        end
        S_TWS: begin
          if (!at_end && sp_c) begin sp_d = sp_q + CNT_W'(1); fetch_d = 1'b1; end
          else begin
            if (!at_end) code_d = ST_SYNTAX;
            st_d = S_FIN;
          end
        end
        default: st_d = S_IDLE;
      endcase
      if (st_d == S_FIN && code_d == ST_SYNTAX && st_q != S_IDLE) begin
        epos_d = 7'(sp_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= S_IDLE;
      fetch_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      fetch_q <= fetch_d;
      ov_q    <= wr ? 1'b1 : (pop ? 1'b0 : ov_q);
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q <= sp_d;   len_q <= len_d;   ys_q <= ys_d;   neg_q <= neg_d;
    sep_on_q <= sep_on_d; h2_q <= h2_d; hms_q <= hms_d; tzn_q <= tzn_d;
    tzp_q <= tzp_d; ycnt_q <= ycnt_d; yhi_q <= yhi_d; ylo_q <= ylo_d;
    sep_q <= sep_d; mon_q <= mon_d;   day_q <= day_d; hr_q <= hr_d;
    mi_q <= mi_d;   se_q <= se_d;     zh_q <= zh_d;   zm_q <= zm_d;
    frac_q <= frac_d; nd_q <= nd_d;   unit_q <= unit_d; code_q <= code_d;
    epos_q <= epos_d; tzoff_q <= tzoff_d;
    if (wr) begin
      o_status_q <= code_q;
      o_epos_q   <= (code_q == ST_SYNTAX) ? epos_q : 7'd0;
      if (code_q == ST_OK) begin
        o_year_q  <= neg_q ? -15'(yval) : 15'(yval);
        o_mon_q   <= 4'(mon_q);
        o_day_q   <= 5'(day_q);
        o_hr_q    <= 5'(hr_q);
        o_mi_q    <= 6'(mi_q);
        o_se_q    <= 6'(se_q);
        o_frac_q  <= frac_q;
        o_unit_q  <= unit_q;
        o_tzp_q   <= tzp_q;
        o_tzoff_q <= tzoff_q;
      end else begin
        o_year_q <= '0; o_mon_q <= '0; o_day_q <= '0; o_hr_q <= '0; o_mi_q <= '0;
        o_se_q <= '0; o_frac_q <= '0; o_unit_q <= '0; o_tzp_q <= 1'b0; o_tzoff_q <= '0;
      end
    end
  end

  assign empty               = !ov_q;
  assign status_o            = o_status_q;
  assign error_position_o    = o_epos_q;
  assign year_o              = o_year_q;
  assign month_o             = o_mon_q;
  assign day_o               = o_day_q;
  assign hour_o              = o_hr_q;
  assign minute_o            = o_mi_q;
  assign second_o            = o_se_q;
  assign fraction_atto_o     = o_frac_q;
  assign best_unit_o         = o_unit_q;
  assign tz_present_o        = o_tzp_q;
  assign tz_offset_minutes_o = o_tzoff_q;

endmodule

[sv/iso8601_datetime_parser_core.sv]
`timescale 1ns / 1ps
// iso8601_datetime_parser_core: top level of the ISO 8601 date-time parser.
// Depends on idp_pkg, idp_front, idp_scan.
//
// Input channel: one character per transfer (push/full). last_char_i marks
// the final character; it closes the string and starts the scan.
// Result channel: one result per string (empty/pop); the oldest result sits
// on the result ports while empty is low.
// Loading costs one cycle per character while full is low. The scan walks
// the stored string through the buffer's single registered read port: for
// each character it presents the address, then decides; each field gets a
// check step, and the fraction is padded to 18 digits at the end.
// full stays high from the last character until the scan releases the
// buffer, so strings are parsed one at a time.
// Strings longer than 64 characters drop the excess and report a syntax
// error at position 64.
// Reset clears the loader count, the job handoff, the scanner state and the
// result-valid flag; the buffer and the result data are not cleared.
// If the receiver stalls, the result is held and a finished scan waits for
// the result slot, holding full high meanwhile.
module iso8601_datetime_parser_core import idp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  char_byte_i,
  input  logic        last_char_i,
  output logic        empty,
  input  logic        pop,
  output logic [3:0]  status_o,
  output logic [6:0]  error_position_o,
  output logic [14:0] year_o,
  output logic [3:0]  month_o,
  output logic [4:0]  day_o,
  output logic [4:0]  hour_o,
  output logic [5:0]  minute_o,
  output logic [5:0]  second_o,
  output logic [59:0] fraction_atto_o,
  output logic [3:0]  best_unit_o,
  output logic        tz_present_o,
  output logic [11:0] tz_offset_minutes_o
);

  idp_job_t          job;
  logic              rel;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;

  // front: buffer loader
  idp_front u_front (
    .clk_i, .rst_ni, .push, .full, .char_byte_i, .last_char_i,
    .job_o(job), .release_i(rel), .rd_addr_i(rd_addr), .rd_data_o(rd_data)
  );

  // back: scanner and result register
  idp_scan u_scan (
    .clk_i, .rst_ni, .job_i(job), .release_o(rel), .rd_addr_o(rd_addr),
    .rd_data_i(rd_data), .empty, .pop, .status_o, .error_position_o, .year_o,
    .month_o, .day_o, .hour_o, .minute_o, .second_o, .fraction_atto_o,
    .best_unit_o, .tz_present_o, .tz_offset_minutes_o
  );

endmodule

[sv/idp_checker.sv]
`timescale 1ns / 1ps
// idp_checker: port-level assertions for the parser, bound to the top level.
// Depends on idp_pkg.
module idp_checker import idp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [3:0]  status_o,
  input logic [6:0]  error_position_o,
  input logic [14:0] year_o,
  input logic        tz_present_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> !empty)
    else $error("result dropped while stalled");

  a_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(status_o))
    else $error("status changed while stalled");

  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> status_o <= ST_ZMIN)
    else $error("status code out of range");

  a_epos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_SYNTAX) |-> error_position_o == 7'd0)
    else $error("error position without syntax error");

  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o != ST_OK) |-> (year_o == 15'd0 && !tz_present_o))
    else $error("error result carries field data");

endmodule

bind iso8601_datetime_parser_core idp_checker u_idp_checker (
  .clk_i, .rst_ni, .empty, .pop, .status_o, .error_position_o, .year_o,
  .tz_present_o
);
